@@ sv/rss_pkg.sv @@
// Package for the rank select and remove block.
// Holds the request and response payload types and the register reset value.
// No dependencies.
package rss_pkg;

   localparam int unsigned FIELD_W = 17;
   localparam logic [FIELD_W-1:0] SIZE_RESET = 17'h10000;
   localparam logic ACTION_REFILL = 1'b0;
   localparam logic ACTION_SELECT = 1'b1;

   typedef struct packed {
      logic               action;
      logic [FIELD_W-1:0] rank;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] chosen_value;
      logic               out_of_range;
      logic [FIELD_W-1:0] left_count;
   } rsp_type;

endpackage

@@ sv/rss_tree_ram.sv @@
// Count tree storage of the rank select and remove block.
// Single write port and one read port with registered read data.
// No dependencies.
module rss_tree_ram #(
   parameter int unsigned DEPTH = 65536,
   parameter int unsigned AW    = 16,
   parameter int unsigned DW    = 17
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rank_select_and_remove.sv @@
// Rank select and remove: top level with the sequencer around the count tree memory.
// Flow: an error or an empty refill answers straight from idle; a refill writes one tree entry a cycle;
// a select runs descent steps (read, compare) down to step one, then update hops (read, write).
// Throughput: one item at a time, bounded by the single memory read and write port.
// Reset: synchronous; the set is empty and the size register returns to 65536.
// Results are strobed for one cycle and the receiver cannot stall them.
module rank_select_and_remove
   import rss_pkg::*;
#(
   parameter int unsigned MAX_ELEMENTS = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_payload,
   output logic               rsp_valid,
   output rsp_type            rsp_payload,
   input  logic               csr_we,
   input  logic [FIELD_W-1:0] csr_wdata
);

   localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
   localparam int unsigned XW = (CW > FIELD_W) ? CW : FIELD_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FILL,
      S_DREAD,
      S_DCMP,
      S_UREAD,
      S_UWRITE
   } state_type;

   state_type          state_ff;
   logic [FIELD_W-1:0] size_ff;
   logic [CW-1:0]      tree_size_ff;
   logic [CW-1:0]      remaining_ff;
   logic [CW-1:0]      top_ff;
   logic [CW-1:0]      idx_ff;
   logic [CW-1:0]      pos_ff;
   logic [CW-1:0]      step_ff;
   logic [CW-1:0]      want_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [CW-1:0]      mem_wdata;
   logic [AW-1:0]      mem_raddr;
   logic [CW-1:0]      mem_rdata;

   logic [XW-1:0]      size_ext;
   logic [XW-1:0]      max_ext;
   logic [XW-1:0]      fill_n_ext;
   logic [CW-1:0]      fill_n;
   logic               rank_bad;
   logic [CW:0]        desc_nxt;
   logic [CW:0]        desc_addr;
   logic               desc_take;
   logic [CW-1:0]      desc_found;
   logic [CW-1:0]      idx_low;
   logic [CW:0]        upd_nxt;
   logic [CW:0]        idx_addr;

   always_comb begin
      size_ext   = XW'(size_ff);
      max_ext    = XW'(MAX_ELEMENTS);
      fill_n_ext = (size_ext > max_ext) ? max_ext : size_ext;
      fill_n     = fill_n_ext[CW-1:0];
      rank_bad   = (req_payload.rank == '0) ||
                   (XW'(req_payload.rank) > XW'(remaining_ff));
      desc_nxt   = {1'b0, pos_ff} + {1'b0, step_ff};
      desc_addr  = desc_nxt - (CW+1)'(1);
      desc_take  = (desc_nxt <= {1'b0, tree_size_ff}) && (mem_rdata < want_ff);
      desc_found = desc_take ? desc_nxt[CW-1:0] + CW'(1) : pos_ff + CW'(1);
      idx_low    = idx_ff & (~idx_ff + CW'(1));
      upd_nxt    = {1'b0, idx_ff} + {1'b0, idx_low};
      idx_addr   = {1'b0, idx_ff} - (CW+1)'(1);
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_addr[AW-1:0];
      mem_wdata = idx_low;
      mem_raddr = desc_addr[AW-1:0];
      case (state_ff)
         S_FILL: begin
            mem_we = 1'b1;
         end
         S_UREAD: begin
            mem_raddr = idx_addr[AW-1:0];
         end
         S_UWRITE: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata - CW'(1);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   rss_tree_ram #(
      .DEPTH (MAX_ELEMENTS),
      .AW    (AW),
      .DW    (CW)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= SIZE_RESET;
         tree_size_ff <= '0;
         remaining_ff <= '0;
         top_ff       <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            size_ff <= csr_wdata;
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  if (req_payload.action == ACTION_REFILL) begin
                     tree_size_ff <= fill_n;
                     remaining_ff <= fill_n;
                     idx_ff       <= CW'(1);
                     if (fill_n == '0) begin
                        rsp_valid_ff        <= 1'b1;
                        rsp_ff.chosen_value <= '0;
                        rsp_ff.out_of_range <= 1'b0;
                        rsp_ff.left_count   <= '0;
                     end else begin
                        state_ff <= S_FILL;
                     end
                  end else if (rank_bad) begin
                     rsp_valid_ff        <= 1'b1;
                     rsp_ff.chosen_value <= '0;
                     rsp_ff.out_of_range <= 1'b1;
                     rsp_ff.left_count   <= FIELD_W'(remaining_ff);
                  end else begin
                     want_ff  <= CW'(req_payload.rank);
                     pos_ff   <= '0;
                     step_ff  <= top_ff;
                     state_ff <= S_DREAD;
                  end
               end
            end
            S_FILL: begin
               if (idx_low == idx_ff) begin
                  top_ff <= idx_ff;
               end
               if (idx_ff == tree_size_ff) begin
                  state_ff            <= S_IDLE;
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.chosen_value <= '0;
                  rsp_ff.out_of_range <= 1'b0;
                  rsp_ff.left_count   <= FIELD_W'(remaining_ff);
               end else begin
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            S_DREAD: begin
               state_ff <= S_DCMP;
            end
            S_DCMP: begin
               if (desc_take) begin
                  pos_ff  <= desc_nxt[CW-1:0];
                  want_ff <= want_ff - mem_rdata;
               end
               step_ff <= step_ff >> 1;
               if (step_ff == CW'(1)) begin
                  idx_ff              <= desc_found;
                  rsp_ff.chosen_value <= FIELD_W'(desc_found);
                  state_ff            <= S_UREAD;
               end else begin
                  state_ff <= S_DREAD;
               end
            end
            S_UREAD: begin
               state_ff <= S_UWRITE;
            end
            S_UWRITE: begin
               if (upd_nxt > {1'b0, tree_size_ff}) begin
                  state_ff            <= S_IDLE;
                  remaining_ff        <= remaining_ff - CW'(1);
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.out_of_range <= 1'b0;
                  rsp_ff.left_count   <= FIELD_W'(remaining_ff - CW'(1));
               end else begin
                  idx_ff   <= upd_nxt[CW-1:0];
                  state_ff <= S_UREAD;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ tb/rank_select_and_remove_tb.sv @@
// Self-checking testbench for the rank select and remove block.
// Drives a directed table and then random phases, checking every transfer against its own
// count tree or a planned result; depends on rss_pkg and rank_select_and_remove.
module rank_select_and_remove_tb;
   import rss_pkg::*;

   localparam int unsigned SET_MAX = 65536;
   localparam logic [FIELD_W-1:0] RANK_TOP = 17'h1FFFF;

   typedef enum logic {
      ROW_ITEM,
      ROW_SIZE
   } row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [FIELD_W-1:0] size_value;
      req_type            item;
      logic               known;
      rsp_type            result;
   } plan_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_payload;
   logic               rsp_valid;
   rsp_type            rsp_payload;
   logic               csr_we;
   logic [FIELD_W-1:0] csr_wdata;

   bit [FIELD_W-1:0]   size_reg = SIZE_RESET;
   bit [FIELD_W-1:0]   tree_counts [1:SET_MAX];
   int unsigned        latched_size = 0;
   bit [FIELD_W-1:0]   values_left = '0;

   rsp_type            pending_results[$];
   rsp_type            oldest;
   plan_row_type       plan[$];
   int unsigned        mismatch_count = 0;

   rank_select_and_remove #(
      .MAX_ELEMENTS(SET_MAX)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int unsigned low_one(input int unsigned v);
      return v & (~v + 1);
   endfunction

   // Rebuilds, selects and removes exactly as the block should, on its own copy of the tree.
   function automatic rsp_type predict_item(input req_type item);
      rsp_type          res;
      int unsigned      n, limit, i, pos, step, nxt;
      bit [FIELD_W:0]   want;
      res = '0;
      if (item.action == ACTION_REFILL) begin
         n = (size_reg > SET_MAX) ? SET_MAX : size_reg;
         limit = (n > latched_size) ? n : latched_size;
         for (i = 1; i <= limit; i++) begin
            tree_counts[i] = (i <= n) ? FIELD_W'(low_one(i)) : '0;
         end
         latched_size = n;
         values_left = FIELD_W'(n);
      end else if (item.rank == 0 || item.rank > values_left) begin
         res.out_of_range = 1'b1;
      end else begin
         pos = 0;
         step = 1;
         while (step <= latched_size / 2) step = step << 1;
         want = (FIELD_W+1)'(item.rank);
         while (step != 0) begin
            nxt = pos + step;
            if (nxt <= latched_size && tree_counts[nxt] < want) begin
               pos = nxt;
               want = want - tree_counts[nxt];
            end
            step = step >> 1;
         end
         pos = pos + 1;
         res.chosen_value = FIELD_W'(pos);
         while (pos != 0 && pos <= latched_size) begin
            tree_counts[pos] = tree_counts[pos] - 1'b1;
            pos = pos + low_one(pos);
         end
         values_left = values_left - 1'b1;
      end
      res.left_count = values_left;
      return res;
   endfunction

   function automatic void plan_item(input logic act, input logic [FIELD_W-1:0] rank);
      plan_row_type row;
      row = '{ROW_ITEM, '0, '{act, rank}, 1'b0, '0};
      plan.push_back(row);
   endfunction

   function automatic void plan_known(input logic act, input logic [FIELD_W-1:0] rank,
                                      input logic [FIELD_W-1:0] chosen, input logic oor,
                                      input logic [FIELD_W-1:0] left);
      plan_row_type row;
      row = '{ROW_ITEM, '0, '{act, rank}, 1'b1, '{chosen, oor, left}};
      plan.push_back(row);
   endfunction

   function automatic void plan_size(input logic [FIELD_W-1:0] value);
      plan_row_type row;
      row = '{ROW_SIZE, value, '0, 1'b0, '0};
      plan.push_back(row);
   endfunction

   // Offers one item and holds it until the transfer; start stays high unless a gap follows.
   task automatic send_item(input req_type item, input int unsigned idle_pct,
                            input logic known, input rsp_type typed);
      rsp_type predicted;
      req_payload <= item;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = predict_item(item);
      pending_results.push_back(known ? typed : predicted);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // The size register is only written once the block has drained.
   task automatic write_size(input logic [FIELD_W-1:0] value);
      start <= 1'b0;
      while (pending_results.size() != 0 || busy) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      size_reg = value;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("rsp transfer with nothing expected: value %0d", rsp_payload.chosen_value);
            mismatch_count++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_payload.chosen_value !== oldest.chosen_value) begin
               $error("chosen_value: expected %0d, got %0d",
                      oldest.chosen_value, rsp_payload.chosen_value);
               mismatch_count++;
            end
            if (rsp_payload.out_of_range !== oldest.out_of_range) begin
               $error("out_of_range: expected %0d, got %0d",
                      oldest.out_of_range, rsp_payload.out_of_range);
               mismatch_count++;
            end
            if (rsp_payload.left_count !== oldest.left_count) begin
               $error("left_count: expected %0d, got %0d",
                      oldest.left_count, rsp_payload.left_count);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      req_type          item;
      int unsigned      seg, k, r, idle_pct;
      logic [FIELD_W-1:0] new_size;
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Selects on the empty set, then the full default size and its extremes.
      plan_known(ACTION_SELECT, 17'd1, 17'd0, 1'b1, 17'd0);
      plan_known(ACTION_SELECT, 17'd0, 17'd0, 1'b1, 17'd0);
      plan_known(ACTION_REFILL, 17'd0, 17'd0, 1'b0, 17'd65536);
      plan_known(ACTION_SELECT, 17'd65536, 17'd65536, 1'b0, 17'd65535);
      plan_known(ACTION_SELECT, 17'd1, 17'd1, 1'b0, 17'd65534);
      plan_known(ACTION_SELECT, RANK_TOP, 17'd0, 1'b1, 17'd65534);
      plan_known(ACTION_SELECT, 17'd0, 17'd0, 1'b1, 17'd65534);
      // A new size does not take effect until the next refill.
      plan_size(17'd5);
      plan_item(ACTION_SELECT, 17'd65534);
      plan_known(ACTION_REFILL, RANK_TOP, 17'd0, 1'b0, 17'd5);
      plan_item(ACTION_SELECT, 17'd3);
      plan_item(ACTION_SELECT, 17'd3);
      plan_known(ACTION_SELECT, 17'd4, 17'd0, 1'b1, 17'd3);
      plan_item(ACTION_REFILL, 17'd2);
      plan_item(ACTION_SELECT, 17'd5);
      plan_size(17'd0);
      plan_known(ACTION_REFILL, 17'd0, 17'd0, 1'b0, 17'd0);
      plan_known(ACTION_SELECT, 17'd1, 17'd0, 1'b1, 17'd0);
      plan_size(RANK_TOP);
      plan_known(ACTION_REFILL, 17'd0, 17'd0, 1'b0, 17'd65536);
      plan_item(ACTION_SELECT, 17'd32768);
      plan_size(17'd1);
      plan_known(ACTION_REFILL, 17'd0, 17'd0, 1'b0, 17'd1);
      plan_known(ACTION_SELECT, 17'd1, 17'd1, 1'b0, 17'd0);
      plan_known(ACTION_SELECT, 17'd1, 17'd0, 1'b1, 17'd0);

      foreach (plan[k]) begin
         if (plan[k].kind == ROW_SIZE) begin
            write_size(plan[k].size_value);
         end else begin
            send_item(plan[k].item, 33, plan[k].known, plan[k].result);
         end
      end

      // Random phases: mostly valid ranks within a refilled set, with noise mixed in.
      for (seg = 0; seg < 12; seg++) begin
         idle_pct = (seg < 4) ? 33 : (seg < 8) ? 50 : 0;
         r = $urandom_range(9);
         if (r < 7) begin
            new_size = FIELD_W'($urandom_range(1, 64));
         end else if (r < 9) begin
            new_size = FIELD_W'($urandom_range(65, 3000));
         end else begin
            new_size = FIELD_W'($urandom_range(0, 3));
         end
         write_size(new_size);
         item.action = ACTION_REFILL;
         item.rank = FIELD_W'($urandom_range(0, RANK_TOP));
         send_item(item, idle_pct, 1'b0, '0);
         for (k = 0; k < 82; k++) begin
            r = $urandom_range(99);
            if (r < 5 || (values_left == 0 && r < 60)) begin
               item.action = ACTION_REFILL;
               item.rank = FIELD_W'($urandom_range(0, RANK_TOP));
            end else if (r < 85 && values_left != 0) begin
               item.action = ACTION_SELECT;
               item.rank = FIELD_W'($urandom_range(1, values_left));
            end else if (r < 92) begin
               item.action = ACTION_SELECT;
               item.rank = '0;
            end else begin
               item.action = ACTION_SELECT;
               item.rank = FIELD_W'($urandom_range(values_left + 1, RANK_TOP));
            end
            send_item(item, idle_pct, 1'b0, '0);
         end
      end

      start <= 1'b0;
      while (pending_results.size() != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #200000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/rss_pkg.sv
sv/rss_tree_ram.sv
sv/rank_select_and_remove.sv
tb/rank_select_and_remove_tb.sv
